// ===== src/depth_patch_median_range_check_core_macros.svh =====
// Assertion macros for the depth patch median core.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef DEPTH_PATCH_MEDIAN_RANGE_CHECK_CORE_MACROS_SVH
`define DEPTH_PATCH_MEDIAN_RANGE_CHECK_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define DPMRC_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DPMRC_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/dpmrc_pkg.sv =====
// Shared constants and types for the depth patch median core.
// No dependencies.
package dpmrc_pkg;

    localparam int PATCH_RADIUS = 10;
    localparam int WINDOW_SIDE  = 2 * PATCH_RADIUS + 1;
    localparam int STORE_DEPTH  = WINDOW_SIDE * WINDOW_SIDE;
    localparam int IDX_W        = $clog2(STORE_DEPTH);
    localparam int CNT_W        = $clog2(STORE_DEPTH + 1);

    localparam int DEPTH_W  = 16;
    localparam int KEPT_W   = 10;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    typedef logic [DEPTH_W-1:0]  t_depth;
    typedef logic [CNT_W-1:0]    t_count;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_NEAR  = 2'd2;
    localparam t_status STATUS_FAR   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_VALID_FLOOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT   = 2'd2;

    localparam t_depth RST_VALID_FLOOR = 16'd10;
    localparam t_depth RST_NEAR_LIMIT  = 16'd300;
    localparam t_depth RST_FAR_LIMIT   = 16'd6000;

endpackage

// ===== src/dpmrc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dpmrc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/depth_patch_median_range_check_core.sv =====
// Depth patch median core: keeps window samples above a floor, finds the upper median
// by a bitwise radix select over the sample RAM, and grades it against range limits.
// Depends on dpmrc_pkg, dpmrc_ram and depth_patch_median_range_check_core_macros.svh.
// Input: one sample word per cycle while collecting; after the marked last word the input
//   stalls until the select finishes and the result word is loaded.
// Throughput: the select runs 16 passes over the sample RAM, one read per cycle.
// Reset: limits return to 10/300/6000 mm, kept count clears; sample RAM is not cleared.
`include "depth_patch_median_range_check_core_macros.svh"

module depth_patch_median_range_check_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dpmrc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dpmrc_pkg::DEPTH_W-1:0]     i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [dpmrc_pkg::DEPTH_W-1:0]     i_depth_sample,
    input  logic                              i_window_end,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [dpmrc_pkg::DEPTH_W-1:0]     o_median_depth,
    output logic [dpmrc_pkg::KEPT_W-1:0]      o_kept_count,
    output logic [dpmrc_pkg::STATUS_W-1:0]    o_status
);

    import dpmrc_pkg::*;

    typedef enum logic [1:0] {
        S_COLLECT,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state           r_state;
    t_depth           r_floor, r_near, r_far;
    t_count           r_kept;
    t_count           r_win_n;
    t_count           r_rank;
    t_count           r_cnt;
    logic [IDX_W-1:0] r_addr;
    logic             r_issuing;
    logic             r_rd_vld;
    logic             r_rd_last;
    t_depth           r_prefix;
    t_depth           r_hi_mask;
    t_depth           r_bit;
    logic             r_out_vld;
    t_depth           r_median;
    t_count           r_kept_out;
    t_status          r_status;

    logic   in_acc;
    logic   keep;
    t_count n_kept;
    t_depth rd_data;
    logic   match;
    t_count c_total;
    logic   pass_end;
    t_depth n_prefix;
    logic   out_free;
    t_status n_status;

    assign o_in_stall = (r_state != S_COLLECT);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign keep       = (i_depth_sample > r_floor) && (r_kept < CNT_W'(STORE_DEPTH));
    assign n_kept     = keep ? r_kept + t_count'(1) : r_kept;

    dpmrc_ram #(
        .WIDTH(DEPTH_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (in_acc && keep),
        .i_waddr(r_kept[IDX_W-1:0]),
        .i_wdata(i_depth_sample),
        .i_raddr(r_addr),
        .o_rdata(rd_data)
    );

    assign match    = r_rd_vld && (((rd_data ^ r_prefix) & r_hi_mask) == '0)
                      && ((rd_data & r_bit) == '0);
    assign c_total  = match ? r_cnt + t_count'(1) : r_cnt;
    assign pass_end = r_rd_vld && r_rd_last;
    assign n_prefix = (r_rank < c_total) ? r_prefix : (r_prefix | r_bit);
    assign out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        if (r_win_n == '0) begin
            n_status = STATUS_EMPTY;
        end else if (r_prefix < r_near) begin
            n_status = STATUS_NEAR;
        end else if (r_prefix > r_far) begin
            n_status = STATUS_FAR;
        end else begin
            n_status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_COLLECT;
            r_floor   <= RST_VALID_FLOOR;
            r_near    <= RST_NEAR_LIMIT;
            r_far     <= RST_FAR_LIMIT;
            r_kept    <= '0;
            r_issuing <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VALID_FLOOR: r_floor <= i_cfg_wdata;
                    CFG_NEAR_LIMIT:  r_near  <= i_cfg_wdata;
                    CFG_FAR_LIMIT:   r_far   <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (r_out_vld && !i_out_stall && r_state != S_FINISH) begin
                r_out_vld <= 1'b0;
            end

            r_rd_vld <= r_issuing;
            if (r_issuing) begin
                r_rd_last <= (r_addr == IDX_W'(r_win_n - t_count'(1)));
                if (r_addr == IDX_W'(r_win_n - t_count'(1))) begin
                    r_issuing <= 1'b0;
                end
                r_addr <= r_addr + IDX_W'(1);
            end

            case (r_state)
                S_COLLECT: begin
                    if (in_acc) begin
                        if (i_window_end) begin
                            r_kept    <= '0;
                            r_win_n   <= n_kept;
                            r_rank    <= n_kept >> 1;
                            r_cnt     <= '0;
                            r_prefix  <= '0;
                            r_hi_mask <= '0;
                            r_bit     <= {1'b1, {(DEPTH_W-1){1'b0}}};
                            r_addr    <= '0;
                            if (n_kept == '0) begin
                                r_state <= S_FINISH;
                            end else begin
                                r_issuing <= 1'b1;
                                r_state   <= S_SCAN;
                            end
                        end else begin
                            r_kept <= n_kept;
                        end
                    end
                end
                S_SCAN: begin
                    if (pass_end) begin
                        r_prefix  <= n_prefix;
                        if (!(r_rank < c_total)) begin
                            r_rank <= r_rank - c_total;
                        end
                        r_hi_mask <= r_hi_mask | r_bit;
                        r_bit     <= r_bit >> 1;
                        r_cnt     <= '0;
                        if (r_bit[0]) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_addr    <= '0;
                            r_issuing <= 1'b1;
                        end
                    end else begin
                        r_cnt <= c_total;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_median   <= r_prefix;
                        r_kept_out <= r_win_n;
                        r_status   <= n_status;
                        r_state    <= S_COLLECT;
                    end
                end
                default: r_state <= S_COLLECT;
            endcase
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_median_depth = r_median;
    assign o_kept_count   = KEPT_W'(r_kept_out);
    assign o_status       = r_status;

    `DPMRC_ASSERT_IMP(a_kept_bound, 1'b1, r_kept <= CNT_W'(STORE_DEPTH), "kept count past store depth")
    `DPMRC_ASSERT_IMP(a_rank_bound, r_state == S_SCAN, r_rank < r_win_n, "rank outside window")
    `DPMRC_ASSERT_IMP(a_empty_zero, o_out_valid && o_status == STATUS_EMPTY,
        o_median_depth == '0 && o_kept_count == '0, "empty window word carries data")
    `DPMRC_ASSERT_NXT(a_finish_load, r_state == S_FINISH && out_free, o_out_valid,
        "finished select did not load output")

endmodule

// ===== bench/patch_median_checker.sv =====
// Checker for the depth patch median core: watches the config port and both word channels,
// predicts each window's upper median, kept count and range status, and compares results.
// Depends on dpmrc_pkg.
module patch_median_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dpmrc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dpmrc_pkg::DEPTH_W-1:0]   i_cfg_wdata,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [dpmrc_pkg::DEPTH_W-1:0]   i_depth_sample,
    input  logic                            i_window_end,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [dpmrc_pkg::DEPTH_W-1:0]   i_median_depth,
    input  logic [dpmrc_pkg::KEPT_W-1:0]    i_kept_count,
    input  logic [dpmrc_pkg::STATUS_W-1:0]  i_status,
    output int                              o_mismatch_count,
    output int                              o_waiting_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import dpmrc_pkg::*;

    typedef struct packed {
        t_depth              median;
        logic [KEPT_W-1:0]   kept;
        t_status             status;
    } t_window_report;

    t_depth         floor_mm;
    t_depth         near_mm;
    t_depth         far_mm;
    t_depth         sorted_kept [STORE_DEPTH];
    int             kept_n;
    t_window_report window_reports [$];

    function automatic t_status grade_depth(t_depth m);
        if (m < near_mm)
            return STATUS_NEAR;
        if (m > far_mm)
            return STATUS_FAR;
        return STATUS_OK;
    endfunction

    task automatic keep_sample(input t_depth d);
        int pos;
        if (d > floor_mm && kept_n < STORE_DEPTH) begin
            pos = kept_n;
            while (pos > 0 && sorted_kept[pos-1] > d) begin
                sorted_kept[pos] = sorted_kept[pos-1];
                pos--;
            end
            sorted_kept[pos] = d;
            kept_n++;
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_window_report want;
        if (!i_rst_n) begin
            floor_mm = RST_VALID_FLOOR;
            near_mm  = RST_NEAR_LIMIT;
            far_mm   = RST_FAR_LIMIT;
            kept_n   = 0;
            window_reports.delete();
            o_mismatch_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (window_reports.size() == 0) begin
                    $error("unexpected word: median_depth %0d kept_count %0d status %0d",
                           i_median_depth, i_kept_count, i_status);
                    o_mismatch_count++;
                end else begin
                    want = window_reports.pop_front();
                    if (i_median_depth !== want.median) begin
                        $error("median_depth: expected %0d, got %0d", want.median, i_median_depth);
                        o_mismatch_count++;
                    end
                    if (i_kept_count !== want.kept) begin
                        $error("kept_count: expected %0d, got %0d", want.kept, i_kept_count);
                        o_mismatch_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        o_mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VALID_FLOOR: floor_mm = i_cfg_wdata;
                    CFG_NEAR_LIMIT:  near_mm  = i_cfg_wdata;
                    CFG_FAR_LIMIT:   far_mm   = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                keep_sample(i_depth_sample);
                if (i_window_end) begin
                    want.kept = KEPT_W'(kept_n);
                    if (kept_n == 0) begin
                        want.median = '0;
                        want.status = STATUS_EMPTY;
                    end else begin
                        want.median = sorted_kept[kept_n / 2];
                        want.status = grade_depth(want.median);
                    end
                    window_reports.insert(window_reports.size(), want);
                    kept_n = 0;
                end
            end
        end
        o_waiting_count = window_reports.size();
    end

endmodule

// ===== bench/depth_patch_median_range_check_core_test.sv =====
// Testbench top for the depth patch median core: drives directed and random depth windows
// under several limit settings and idling mixes, and reports the verdict.
// Depends on dpmrc_pkg, depth_patch_median_range_check_core and patch_median_checker.
module depth_patch_median_range_check_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dpmrc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_VALID_FLOOR;
    logic [DEPTH_W-1:0]    i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [DEPTH_W-1:0]    i_depth_sample = '0;
    logic                  i_window_end = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [DEPTH_W-1:0]    o_median_depth;
    logic [KEPT_W-1:0]     o_kept_count;
    logic [STATUS_W-1:0]   o_status;

    int     mismatch_count;
    int     waiting_count;
    int     cycle_count = 0;
    int     word_gap_pct = 0;
    int     result_stall_pct = 0;
    int     words_sent = 0;
    t_depth floor_mm = RST_VALID_FLOOR;

    depth_patch_median_range_check_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_depth_sample (i_depth_sample),
        .i_window_end   (i_window_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_median_depth (o_median_depth),
        .o_kept_count   (o_kept_count),
        .o_status       (o_status)
    );

    patch_median_checker checker_u (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_depth_sample   (i_depth_sample),
        .i_window_end     (i_window_end),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_median_depth   (o_median_depth),
        .i_kept_count     (o_kept_count),
        .i_status         (o_status),
        .o_mismatch_count (mismatch_count),
        .o_waiting_count  (waiting_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < result_stall_pct);
    end

    task automatic load_limits(input t_depth floor_v, input t_depth near_v, input t_depth far_v);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_VALID_FLOOR;
        i_cfg_wdata <= floor_v;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_NEAR_LIMIT;
        i_cfg_wdata <= near_v;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_FAR_LIMIT;
        i_cfg_wdata <= far_v;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_SPARE;
        i_cfg_wdata <= t_depth'($urandom);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        floor_mm = floor_v;
    endtask

    task automatic send_word(input t_depth d, input logic last);
        while ($urandom_range(99) < word_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_depth_sample <= d;
        i_window_end   <= last;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (waiting_count != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic t_depth next_depth(input t_depth prev);
        case ($urandom_range(9))
            0: return t_depth'($urandom_range(0, floor_mm));
            1: return t_depth'($urandom);
            2: return prev;
            3: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return t_depth'($urandom_range(0, 8000));
        endcase
    endfunction

    task automatic run_random(input int word_budget);
        int     stop_at;
        int     len;
        t_depth prev;
        stop_at = words_sent + word_budget;
        prev    = '0;
        while (words_sent < stop_at) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
            for (int i = 0; i < len; i++) begin
                prev = next_depth(prev);
                send_word(prev, i == len - 1);
            end
        end
        drain();
    endtask

    task automatic big_window(input int valid_n, input bit with_noise);
        int kept;
        kept = 0;
        while (kept < valid_n) begin
            if (with_noise && $urandom_range(7) == 0) begin
                send_word(t_depth'($urandom_range(0, floor_mm)), 1'b0);
            end else begin
                kept++;
                send_word(t_depth'(floor_mm + 1 + $urandom_range(0, 2000)), kept == valid_n);
            end
        end
        drain();
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(16'hFFFF, 1'b1);
        send_word(16'd0, 1'b1);
        send_word(16'd10, 1'b1);
        send_word(16'd11, 1'b1);
        send_word(16'd299, 1'b1);
        send_word(16'd300, 1'b1);
        send_word(16'd6000, 1'b1);
        send_word(16'd6001, 1'b1);
        send_word(16'd300, 1'b0);
        send_word(16'd6000, 1'b0);
        send_word(16'd5000, 1'b0);
        send_word(16'd11, 1'b1);
        send_word(16'd7000, 1'b0);
        send_word(16'd7000, 1'b0);
        send_word(16'd100, 1'b1);
        send_word(16'd500, 1'b0);
        send_word(16'd600, 1'b0);
        send_word(16'd5, 1'b1);
        send_word(16'hAAAA, 1'b0);
        send_word(16'h5555, 1'b1);
        drain();

        word_gap_pct = 62;
        load_limits(16'h0000, 16'h0000, 16'hFFFF);
        run_random(20);

        word_gap_pct     = 0;
        result_stall_pct = 62;
        load_limits(16'hFFFF, 16'hFFFF, 16'h0000);
        run_random(10);
        load_limits(16'd50, 16'd4000, 16'd2000);
        run_random(20);

        word_gap_pct     = 32;
        result_stall_pct = 32;
        load_limits(t_depth'($urandom_range(0, 200)), t_depth'($urandom_range(0, 2000)),
                    t_depth'($urandom_range(2000, 8000)));
        big_window(STORE_DEPTH + 2, 1'b1);
        run_random(10);

        word_gap_pct     = 0;
        result_stall_pct = 0;
        load_limits(t_depth'($urandom_range(0, 200)), t_depth'($urandom_range(0, 2000)),
                    t_depth'($urandom_range(2000, 8000)));
        run_random(20);

        word_gap_pct = 62;
        load_limits(t_depth'($urandom_range(0, 200)), t_depth'($urandom_range(0, 2000)),
                    t_depth'($urandom_range(2000, 8000)));
        run_random(20);

        repeat (200) @(negedge i_clk);
        if (mismatch_count == 0 && waiting_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
